>>> src/assert_macros.svh
// Assertion macros shared by the sharpening filter RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off during reset.
`define LSH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define LSH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`else

`define LSH_ASSERT_IMP(label, clk, rst, ante, cons)
`define LSH_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/lsharp_pkg.sv
// Shared types, constants and the per-channel sharpening function
// for the 3x3 Laplacian sharpening filter. No dependencies.
package lsharp_pkg;

  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int PIX_DATA_W  = CHAN_W * NUM_CHAN;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int FW_FIELD_W  = 11;
  localparam int FH_FIELD_W  = 13;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RESET_WIDTH    = 1024;
  localparam int RESET_HEIGHT   = 768;
  localparam int MIN_DIM        = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam int SHARP_GAIN  = 255;
  localparam int SHARP_BIAS  = 57;
  localparam int SHARP_DIV   = 314 + SHARP_BIAS;
  localparam int SHARP_SHIFT = 18;
  localparam int SHARP_RECIP = (SHARP_GAIN * (1 << SHARP_SHIFT) + SHARP_DIV - 1) / SHARP_DIV;
  localparam int SHARP_SAT   = (256 * SHARP_DIV + SHARP_GAIN - 1) / SHARP_GAIN;
  localparam int ACC_W       = 12;
  localparam int SUB_W       = 9;
  localparam int PROD_W      = SUB_W + SHARP_SHIFT;

  typedef struct packed {
    logic has_result;
    logic border;
    logic frame_end;
    logic wr_newer;
    logic wr_older;
  } s1_ctrl_t;

  // 255 * (5c - u - d - l - r + 57) / 371, truncated, clamped to 0..255
  function automatic logic [CHAN_W-1:0] sharpen_chan(
    input logic [CHAN_W-1:0] ce,
    input logic [CHAN_W-1:0] up,
    input logic [CHAN_W-1:0] dn,
    input logic [CHAN_W-1:0] lf,
    input logic [CHAN_W-1:0] rt
  );
    logic signed [ACC_W-1:0] acc;
    logic [SUB_W-1:0]        acc_s;
    logic [PROD_W-1:0]       prod;
    logic [CHAN_W-1:0]       q;
    acc = ACC_W'(SHARP_BIAS)
        + $signed({2'b00, ce, 2'b00}) + $signed({4'b0000, ce})
        - $signed({4'b0000, up}) - $signed({4'b0000, dn})
        - $signed({4'b0000, lf}) - $signed({4'b0000, rt});
    acc_s = acc[SUB_W-1:0];
    prod  = PROD_W'(acc_s) * PROD_W'(SHARP_RECIP);
    if (acc <= $signed(ACC_W'(0))) begin
      q = '0;
    end else if (acc >= $signed(ACC_W'(SHARP_SAT))) begin
      q = '1;
    end else begin
      q = prod[SHARP_SHIFT +: CHAN_W];
    end
    return q;
  endfunction

endpackage

>>> src/laplacian_sharpen_3x3.sv
// Top level of the 3x3 Laplacian sharpening filter for RGB streams.
// Depends on lsharp_pkg, lsharp_ctrl, lsharp_line_store, lsharp_kernel.
//
// Takes RGB pixels in raster order (s_tuser = 0) and returns each pixel one
// row later: border pixels unchanged, interior pixels sharpened with the
// 4-neighbour Laplacian 255*(5c - up - down - left - right + 57)/371,
// clamped to 0..255. The first row gives no output. After the last row,
// send one flush item (s_tuser = 1) per pixel of the final row; the last
// output of the frame carries m_tlast. Pixels after the last row and flushes
// before it are dropped. Writing a frame size restarts the frame. One item
// is taken every clock while no result waits; an accepted item is staged
// with the registered read of the row memories (MAX_WIDTH x 24 bits each,
// the newer one read at two columns per clock), then written to the result
// register. A result that waits on m_tready holds the stage and the input.
`include "assert_macros.svh"

module laplacian_sharpen_3x3 import lsharp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [PIX_DATA_W-1:0]  s_tdata,   // blue_in, green_in, red_in
  input  logic                   s_tuser,   // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [PIX_DATA_W-1:0]  m_tdata,   // blue_out, green_out, red_out
  output logic                   m_tlast
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                  accept;
  s1_ctrl_t              ctrl_next;
  logic [CW-1:0]         rd_col, rd_col_right;
  logic                  s1_valid;
  s1_ctrl_t              s1_ctrl;
  logic [PIX_DATA_W-1:0] s1_px;
  logic [CW-1:0]         s1_col;
  logic                  out_free, s1_go;
  logic [PIX_DATA_W-1:0] centre, right, up;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s1_go    = s1_valid && (!s1_ctrl.has_result || out_free);
  assign s_tready = !s1_valid || s1_go;

  lsharp_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .kind         (s_tuser),
    .ctrl         (ctrl_next),
    .rd_col       (rd_col),
    .rd_col_right (rd_col_right)
  );

  lsharp_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk           (clk),
    .rd_en         (accept),
    .rd_addr       (rd_col),
    .rd_addr_right (rd_col_right),
    .wr_newer      (s1_go && s1_ctrl.wr_newer),
    .wr_older      (s1_go && s1_ctrl.wr_older),
    .wr_addr       (s1_col),
    .newer_data    (s1_px),
    .older_data    (centre),
    .centre        (centre),
    .right         (right),
    .up            (up)
  );

  lsharp_kernel u_kernel (
    .clk      (clk),
    .go       (s1_go),
    .ctrl     (s1_ctrl),
    .px       (s1_px),
    .centre   (centre),
    .up       (up),
    .right    (right),
    .res      (m_tdata),
    .res_last (m_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s1_go && s1_ctrl.has_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl <= ctrl_next;
      s1_px   <= s_tdata;
      s1_col  <= rd_col;
    end
  end

  `LSH_ASSERT_IMP(a_no_result_overwrite, clk, rst, s1_go && s1_ctrl.has_result, out_free)
  `LSH_ASSERT_IMP(a_ready_when_empty, clk, rst, !s1_valid, s_tready)
  `LSH_ASSERT_IMP(a_no_rw_collision, clk, rst, accept && ctrl_next.has_result && s1_go && s1_ctrl.wr_newer, rd_col != s1_col)
  `LSH_ASSERT_NXT(a_result_staged, clk, rst, accept && ctrl_next.has_result, s1_valid && s1_ctrl.has_result)

endmodule

>>> src/lsharp_ctrl.sv
// Frame size registers and row/column counters of the sharpening filter.
// Decides per item what the datapath does. Depends on lsharp_pkg.
module lsharp_ctrl import lsharp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         accept,
  input  logic                         kind,
  output s1_ctrl_t                     ctrl,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_col_right
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int ORW   = $clog2(MAX_HEIGHT);
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  logic [WW-1:0]  frame_width;
  logic [RW-1:0]  frame_height;
  logic [CW-1:0]  in_column, in_column_next;
  logic [RW-1:0]  in_row, in_row_next;
  logic [CW-1:0]  out_column, out_column_next;
  logic [ORW-1:0] out_row, out_row_next;

  logic [31:0] fw_field, fh_field, fw_sat, fh_sat;
  logic [WW:0] in_col_inc, out_col_inc;
  logic [RW:0] out_row_inc;
  logic        in_col_last, out_col_last, out_row_last, in_done;

  always_comb begin
    fw_field = 32'(cfg_data[FW_FIELD_W-1:0]);
    fh_field = 32'(cfg_data[FH_FIELD_W-1:0]);
    if (fw_field < 32'(MIN_DIM)) begin
      fw_sat = 32'(MIN_DIM);
    end else if (fw_field > 32'(MAX_WIDTH)) begin
      fw_sat = 32'(MAX_WIDTH);
    end else begin
      fw_sat = fw_field;
    end
    if (fh_field < 32'(MIN_DIM)) begin
      fh_sat = 32'(MIN_DIM);
    end else if (fh_field > 32'(MAX_HEIGHT)) begin
      fh_sat = 32'(MAX_HEIGHT);
    end else begin
      fh_sat = fh_field;
    end
  end

  assign in_col_inc   = (WW+1)'(in_column) + (WW+1)'(1);
  assign out_col_inc  = (WW+1)'(out_column) + (WW+1)'(1);
  assign out_row_inc  = (RW+1)'(out_row) + (RW+1)'(1);
  assign in_col_last  = in_col_inc >= (WW+1)'(frame_width);
  assign out_col_last = out_col_inc >= (WW+1)'(frame_width);
  assign out_row_last = out_row_inc >= (RW+1)'(frame_height);
  assign in_done      = in_row >= frame_height;

  always_comb begin
    ctrl            = '0;
    rd_col          = in_column;
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    case (kind)
      KIND_PIXEL: begin
        if (!in_done) begin
          ctrl.wr_newer = 1'b1;
          if (in_row != '0) begin
            ctrl.has_result = 1'b1;
            ctrl.wr_older   = 1'b1;
            ctrl.border     = (out_row == '0) || out_row_last
                              || (in_column == '0) || in_col_last;
            if (out_col_last) begin
              out_column_next = '0;
              out_row_next    = out_row + ORW'(1);
            end else begin
              out_column_next = out_column + CW'(1);
            end
          end
          if (in_col_last) begin
            in_column_next = '0;
            in_row_next    = in_row + RW'(1);
          end else begin
            in_column_next = in_column + CW'(1);
          end
        end
      end
      KIND_FLUSH: begin
        rd_col = out_column;
        if (in_done) begin
          ctrl.has_result = 1'b1;
          ctrl.border     = 1'b1;
          if (out_col_last) begin
            ctrl.frame_end  = 1'b1;
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
          end else begin
            out_column_next = out_column + CW'(1);
          end
        end
      end
    endcase
  end

  assign rd_col_right = (rd_col == CW'(MAX_WIDTH - 1)) ? '0 : rd_col + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WW'(RST_W);
      frame_height <= RW'(RST_H);
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= WW'(fw_sat);
        REG_FRAME_HEIGHT: frame_height <= RW'(fh_sat);
      endcase
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (accept) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

endmodule

>>> src/lsharp_line_store.sv
// Two row memories of the sharpening filter: the newer row (two read ports)
// and the older row (one read port), read data registered. Depends on lsharp_pkg.
module lsharp_line_store import lsharp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr_right,
  input  logic                         wr_newer,
  input  logic                         wr_older,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [PIX_DATA_W-1:0]        newer_data,
  input  logic [PIX_DATA_W-1:0]        older_data,
  output logic [PIX_DATA_W-1:0]        centre,
  output logic [PIX_DATA_W-1:0]        right,
  output logic [PIX_DATA_W-1:0]        up
);

  logic [PIX_DATA_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_DATA_W-1:0] older_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_newer) begin
      newer_mem[wr_addr] <= newer_data;
    end
    if (rd_en) begin
      centre <= newer_mem[rd_addr];
      right  <= newer_mem[rd_addr_right];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_older) begin
      older_mem[wr_addr] <= older_data;
    end
    if (rd_en) begin
      up <= older_mem[rd_addr];
    end
  end

endmodule

>>> src/lsharp_kernel.sv
// Sharpening datapath: 4-neighbour Laplacian on three channels, border
// pass-through and the result register. Depends on lsharp_pkg.
module lsharp_kernel import lsharp_pkg::*; (
  input  logic                  clk,
  input  logic                  go,
  input  s1_ctrl_t              ctrl,
  input  logic [PIX_DATA_W-1:0] px,
  input  logic [PIX_DATA_W-1:0] centre,
  input  logic [PIX_DATA_W-1:0] up,
  input  logic [PIX_DATA_W-1:0] right,
  output logic [PIX_DATA_W-1:0] res,
  output logic                  res_last
);

  logic [PIX_DATA_W-1:0] prev_centre;
  logic [PIX_DATA_W-1:0] sharp;

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      sharp[ch*CHAN_W +: CHAN_W] = sharpen_chan(centre[ch*CHAN_W +: CHAN_W],
                                                up[ch*CHAN_W +: CHAN_W],
                                                px[ch*CHAN_W +: CHAN_W],
                                                prev_centre[ch*CHAN_W +: CHAN_W],
                                                right[ch*CHAN_W +: CHAN_W]);
    end
  end

  // hold the centre of the previous column: it is the left neighbour
  always_ff @(posedge clk) begin
    if (go && ctrl.wr_older) begin
      prev_centre <= centre;
    end
    if (go && ctrl.has_result) begin
      res      <= ctrl.border ? centre : sharp;
      res_last <= ctrl.frame_end;
    end
  end

endmodule
